@@ hw/rtl/artdmx_pkg.sv @@
// artdmx_pkg: types, constants and helpers shared by the artdmx packet router
// no dependencies; imported by every artdmx module

package artdmx_pkg;

    // request payload on the input side
    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_of_packet;
    } artdmx_in_t;

    // request payload on the result side
    typedef struct packed {
        logic [2:0] strip_index;
        logic [8:0] channel_index;
        logic [7:0] channel_value;
    } artdmx_out_t;

    // configuration register contents
    typedef struct packed {
        logic [14:0] start_universe;
        logic [3:0]  universe_count;
        logic [9:0]  channels_per_strip;
    } artdmx_cfg_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_UNIVERSE     = 2'd0,
        CFG_UNIVERSE_COUNT     = 2'd1,
        CFG_CHANNELS_PER_STRIP = 2'd2
    } artdmx_cfg_idx_t;

    localparam logic [14:0] START_UNIVERSE_RST     = 15'd0;
    localparam logic [3:0]  UNIVERSE_COUNT_RST     = 4'd8;
    localparam logic [9:0]  CHANNELS_PER_STRIP_RST = 10'd510;

    // hard limits of the strip store
    localparam logic [3:0] MAX_STRIPS   = 4'd8;
    localparam logic [9:0] MAX_CHANNELS = 10'd512;

    // byte offsets within an art-net payload
    localparam logic [9:0] SIG_LEN    = 10'd7;
    localparam logic [9:0] OPC_LO_POS = 10'd8;
    localparam logic [9:0] OPC_HI_POS = 10'd9;
    localparam logic [9:0] UNI_LO_POS = 10'd14;
    localparam logic [9:0] UNI_HI_POS = 10'd15;
    localparam logic [9:0] DATA_START = 10'd18;
    localparam logic [9:0] POS_MAX    = 10'd1023;

    localparam logic [7:0] OPC_LO_BYTE = 8'h00;
    localparam logic [7:0] OPC_HI_BYTE = 8'h50;

    // "Art-Net" signature, one byte per position
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h41;
            3'd1:    c = 8'h72;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h2D;
            3'd4:    c = 8'h4E;
            3'd5:    c = 8'h65;
            3'd6:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/artdmx_cfg_regs.sv @@
// artdmx_cfg_regs: configuration register file of the artdmx router
// depends on artdmx_pkg

module artdmx_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [artdmx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [artdmx_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output artdmx_pkg::artdmx_cfg_t            cfg_o
);
    import artdmx_pkg::*;

    artdmx_cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_START_UNIVERSE:     cfg_next.start_universe     = cfg_wdata[14:0];
                CFG_UNIVERSE_COUNT:     cfg_next.universe_count     = cfg_wdata[3:0];
                CFG_CHANNELS_PER_STRIP: cfg_next.channels_per_strip = cfg_wdata[9:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_universe     <= START_UNIVERSE_RST;
            cfg_reg.universe_count     <= UNIVERSE_COUNT_RST;
            cfg_reg.channels_per_strip <= CHANNELS_PER_STRIP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_o = cfg_reg;

endmodule

@@ hw/rtl/artdmx_parser.sv @@
// artdmx_parser: input register, per-packet header state and write decision
// depends on artdmx_pkg

module artdmx_parser (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  artdmx_pkg::artdmx_cfg_t  cfg_i,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  artdmx_pkg::artdmx_in_t   s_payload,
    output logic                     res_valid,
    input  logic                     res_ready,
    output artdmx_pkg::artdmx_out_t  res_payload
);
    import artdmx_pkg::*;

    logic        in_vld_reg, in_vld_next;
    artdmx_in_t  in_reg;

    logic [9:0]  pos_reg, pos_next;
    logic        sig_ok_reg, sig_ok_next;
    logic        opc_ok_reg, opc_ok_next;
    logic [7:0]  uni_lo_reg, uni_lo_next;
    logic        acc_reg, acc_next;
    logic [2:0]  strip_reg, strip_next;

    logic        adv;
    logic [7:0]  b;
    logic [14:0] uni15;
    logic [14:0] diff;
    logic [3:0]  cnt;
    logic [9:0]  lim;
    logic [9:0]  ch;
    logic        emit;

    assign adv     = in_vld_reg && res_ready;
    assign s_ready = !in_vld_reg || res_ready;
    assign b       = in_reg.packet_byte;

    assign uni15 = {b[6:0], uni_lo_reg};
    assign diff  = uni15 - cfg_i.start_universe;
    assign cnt   = (cfg_i.universe_count > MAX_STRIPS) ? MAX_STRIPS : cfg_i.universe_count;
    assign lim   = (cfg_i.channels_per_strip > MAX_CHANNELS) ? MAX_CHANNELS
                                                              : cfg_i.channels_per_strip;
    assign ch    = pos_reg - DATA_START;
    assign emit  = (pos_reg >= DATA_START) && acc_reg && (ch < lim);

    assign res_valid                 = in_vld_reg && emit;
    assign res_payload.strip_index   = strip_reg;
    assign res_payload.channel_index = ch[8:0];
    assign res_payload.channel_value = b;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_ready) begin
            in_vld_next = s_valid;
        end

        pos_next    = pos_reg;
        sig_ok_next = sig_ok_reg;
        opc_ok_next = opc_ok_reg;
        uni_lo_next = uni_lo_reg;
        acc_next    = acc_reg;
        strip_next  = strip_reg;

        if (adv) begin
            if (pos_reg < SIG_LEN) begin
                if (b != sig_byte(pos_reg[2:0])) begin
                    sig_ok_next = 1'b0;
                end
            end else if (pos_reg == OPC_LO_POS) begin
                opc_ok_next = (b == OPC_LO_BYTE);
            end else if (pos_reg == OPC_HI_POS) begin
                opc_ok_next = opc_ok_reg && (b == OPC_HI_BYTE);
            end else if (pos_reg == UNI_LO_POS) begin
                uni_lo_next = b;
            end else if (pos_reg == UNI_HI_POS) begin
                // high universe bit set means the packet is not accepted
                if (sig_ok_reg && opc_ok_reg && !b[7]
                    && (uni15 >= cfg_i.start_universe)
                    && (diff < {11'd0, cnt})) begin
                    acc_next   = 1'b1;
                    strip_next = diff[2:0];
                end else begin
                    acc_next   = 1'b0;
                end
            end

            if (in_reg.last_of_packet) begin
                pos_next    = '0;
                sig_ok_next = 1'b1;
                opc_ok_next = 1'b0;
                uni_lo_next = '0;
                acc_next    = 1'b0;
                strip_next  = '0;
            end else if (pos_reg < POS_MAX) begin
                pos_next = pos_reg + 10'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            pos_reg    <= '0;
            sig_ok_reg <= 1'b1;
            opc_ok_reg <= 1'b0;
            uni_lo_reg <= '0;
            acc_reg    <= 1'b0;
            strip_reg  <= '0;
        end else begin
            in_vld_reg <= in_vld_next;
            pos_reg    <= pos_next;
            sig_ok_reg <= sig_ok_next;
            opc_ok_reg <= opc_ok_next;
            uni_lo_reg <= uni_lo_next;
            acc_reg    <= acc_next;
            strip_reg  <= strip_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_payload;
        end
    end

    a_emit_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (acc_reg && pos_reg >= DATA_START))
        else $error("write issued for a packet that was not accepted");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_reg.last_of_packet) |=> (pos_reg == '0 && !acc_reg && sig_ok_reg))
        else $error("packet state not cleared after last byte");

    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !in_reg.last_of_packet && pos_reg < POS_MAX)
            |=> (pos_reg == $past(pos_reg) + 10'd1))
        else $error("byte position did not advance by one");

    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> (pos_reg == $past(pos_reg) && acc_reg == $past(acc_reg)))
        else $error("packet state changed without a byte");

endmodule

@@ hw/rtl/artdmx_out_stage.sv @@
// artdmx_out_stage: result register between the parser and the m_ channel
// depends on artdmx_pkg

module artdmx_out_stage (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     res_valid,
    output logic                     res_ready,
    input  artdmx_pkg::artdmx_out_t  res_payload,
    output logic                     m_valid,
    input  logic                     m_ready,
    output artdmx_pkg::artdmx_out_t  m_payload
);
    import artdmx_pkg::*;

    logic        vld_reg, vld_next;
    artdmx_out_t data_reg;

    assign res_ready = !vld_reg || m_ready;

    always_comb begin
        vld_next = vld_reg;
        if (res_ready) begin
            vld_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            data_reg <= res_payload;
        end
    end

    assign m_valid   = vld_reg;
    assign m_payload = data_reg;

endmodule

@@ hw/rtl/artdmx_packet_router.sv @@
// artdmx_packet_router: top level of the art-net dmx packet router
// depends on artdmx_pkg, artdmx_cfg_regs, artdmx_parser, artdmx_out_stage
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  s_       | s_valid / s_ready   | packet_byte, last_of_packet
//  m_       | m_valid / m_ready   | strip_index, channel_index, channel_value
//  cfg_     | cfg_wr_en           | cfg_index, cfg_wdata (no wait, no read-back)
//
// one byte accepted per cycle unless a stall on m_ready holds it off; each byte
// passes through the input register and, if it yields a write, the result
// register. the rate is set by the single header/compare pass between the two
// registers. reset is synchronous on aresetn low and restores the register
// defaults and the start-of-packet state. a stall on m_ready holds the result
// register and backs up into s_ready in the same cycle.

module artdmx_packet_router (
    input  logic                               aclk,
    input  logic                               aresetn,
    // byte stream in
    input  logic                               s_valid,
    output logic                               s_ready,
    input  artdmx_pkg::artdmx_in_t             s_payload,
    // channel writes out
    output logic                               m_valid,
    input  logic                               m_ready,
    output artdmx_pkg::artdmx_out_t            m_payload,
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [artdmx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [artdmx_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import artdmx_pkg::*;

    artdmx_cfg_t cfg;
    logic        res_valid;
    logic        res_ready;
    artdmx_out_t res_payload;

    // start universe, universe count, channel limit
    artdmx_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg_o     (cfg)
    );

    // header checks and per-byte write decision
    artdmx_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_i       (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_payload (res_payload)
    );

    // registered result request
    artdmx_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_payload (res_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload)
    );

endmodule
